### design/hsv2rgb_pkg.sv
// Shared constants for the HSV to RGB converter: scale factors, reciprocal
// constants for the constant divisions, hue sector codes and pipeline depth.
// No dependencies.
package hsv2rgb_pkg;

  localparam int unsigned SectorDegInt   = 60;
  localparam int unsigned FullScaleInt   = 255;
  localparam int unsigned SectorScaleInt = SectorDegInt * FullScaleInt;

  localparam logic [6:0]  SectorDeg   = 7'(SectorDegInt);
  localparam logic [7:0]  FullScale   = 8'(FullScaleInt);
  localparam logic [13:0] SectorScale = 14'(SectorScaleInt);

  // hue / 60 as (hue * RecipSector) >> SectorShift, exact for any 9-bit hue.
  localparam int unsigned SectorShift = 16;
  localparam logic [10:0] RecipSector =
    11'(((1 << SectorShift) + SectorDegInt - 1) / SectorDegInt);

  // x / 255 for x up to 255*255, and x / 15300 for x up to 255*15300,
  // as a multiplication by a rounded-up reciprocal and a shift.
  localparam int unsigned PShift = 24;
  localparam logic [16:0] RecipP =
    17'(((64'd1 << PShift) / 64'(FullScaleInt)) + 64'd1);
  localparam int unsigned QShift = 36;
  localparam logic [22:0] RecipQ =
    23'(((64'd1 << QShift) / 64'(SectorScaleInt)) + 64'd1);

  // Hue sector codes; any other code takes the last permutation.
  localparam logic [3:0] SectorRed     = 4'd0;
  localparam logic [3:0] SectorYellow  = 4'd1;
  localparam logic [3:0] SectorGreen   = 4'd2;
  localparam logic [3:0] SectorCyan    = 4'd3;
  localparam logic [3:0] SectorBlue    = 4'd4;

  // Edges from the accepting edge to the edge at which the result is taken.
  localparam int unsigned PipeDepth = 6;

endpackage

### design/hsv_to_rgb_converter.sv
// HSV to RGB converter: a six-stage pipeline that turns one colour word per
// cycle into 8-bit red, green and blue. Depends on hsv2rgb_pkg.
//
// Usage.
// The input word (hue_degrees, saturation, brightness) is taken at a rising
// edge at which start is high and busy is low. The result word appears on
// red, green and blue for exactly one cycle, marked by done, and is taken at
// the edge that ends that cycle; the receiver cannot hold it off, so the
// pipeline never stalls.
// Throughput is one word every cycle while busy is low. A word passes
// through six register stages, each at most one multiplication deep: hue
// sector, remainder, the q and t numerators, the products with value, the
// reciprocal multiplications for the floored divisions by 255 and 15300,
// and the output register, which is loaded at the same edge as done.
// Reset is synchronous. It clears every valid bit, so no word in flight
// survives it, and busy is high for the cycle after each reset cycle.
// At all other times busy stays low.
// Zero saturation gives grey equal to value; hue codes above 359 take the
// last sector permutation.
module hsv_to_rgb_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [8:0] hue_degrees,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       done,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic        accept;
  logic [19:0] sector_prod;

  // Stage 1: hue sector.
  logic        s1_valid;
  logic [8:0]  s1_hue;
  logic [3:0]  s1_sector;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_val;

  // Stage 2: remainder within the sector and 255 - s.
  logic        s2_valid;
  logic [5:0]  s2_rem;
  logic [3:0]  s2_sector;
  logic [7:0]  s2_sat;
  logic [7:0]  s2_val;
  logic [7:0]  s2_np;

  // Stage 3: numerators of the three terms.
  logic        s3_valid;
  logic [3:0]  s3_sector;
  logic        s3_grey;
  logic [7:0]  s3_val;
  logic [7:0]  s3_np;
  logic [13:0] s3_nq;
  logic [13:0] s3_nt;

  // Stage 4: numerators times value.
  logic        s4_valid;
  logic [3:0]  s4_sector;
  logic        s4_grey;
  logic [7:0]  s4_val;
  logic [15:0] s4_mp;
  logic [21:0] s4_mq;
  logic [21:0] s4_mt;

  // Stage 5: reciprocal products.
  logic        s5_valid;
  logic [3:0]  s5_sector;
  logic        s5_grey;
  logic [7:0]  s5_val;
  logic [32:0] s5_pp;
  logic [44:0] s5_pq;
  logic [44:0] s5_pt;

  logic [7:0]  term_p;
  logic [7:0]  term_q;
  logic [7:0]  term_t;
  logic [7:0]  red_next;
  logic [7:0]  green_next;
  logic [7:0]  blue_next;

  assign accept = start && !busy;

  // busy is a registered copy of rst: it is high in the cycle after each
  // reset cycle, and no word is taken while it is high.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Valid bits travel alongside the data and are the only reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      done     <= s5_valid;
    end
  end

  // The sector is hue / 60, taken from the upper bits of a product with
  // the rounded reciprocal of 60.
  assign sector_prod = 20'(hue_degrees) * 20'(hsv2rgb_pkg::RecipSector);

  always_ff @(posedge clk) begin
    s1_hue    <= hue_degrees;
    s1_sector <= sector_prod[hsv2rgb_pkg::SectorShift +: 4];
    s1_sat    <= saturation;
    s1_val    <= brightness;
  end

  always_ff @(posedge clk) begin
    s2_rem    <= 6'(s1_hue - 9'(s1_sector) * 9'(hsv2rgb_pkg::SectorDeg));
    s2_sector <= s1_sector;
    s2_sat    <= s1_sat;
    s2_val    <= s1_val;
    s2_np     <= hsv2rgb_pkg::FullScale - s1_sat;
  end

  // q falls as the hue moves through the sector, t rises.
  always_ff @(posedge clk) begin
    s3_sector <= s2_sector;
    s3_grey   <= (s2_sat == 8'd0);
    s3_val    <= s2_val;
    s3_np     <= s2_np;
    s3_nq     <= hsv2rgb_pkg::SectorScale - 14'(s2_rem) * 14'(s2_sat);
    s3_nt     <= hsv2rgb_pkg::SectorScale
                 - 14'(hsv2rgb_pkg::SectorDeg - 7'(s2_rem)) * 14'(s2_sat);
  end

  always_ff @(posedge clk) begin
    s4_sector <= s3_sector;
    s4_grey   <= s3_grey;
    s4_val    <= s3_val;
    s4_mp     <= 16'(s3_val) * 16'(s3_np);
    s4_mq     <= 22'(s3_val) * 22'(s3_nq);
    s4_mt     <= 22'(s3_val) * 22'(s3_nt);
  end

  // The rounded-up reciprocals are close enough that the shifted products
  // equal the floored quotients over the whole range of the numerators.
  always_ff @(posedge clk) begin
    s5_sector <= s4_sector;
    s5_grey   <= s4_grey;
    s5_val    <= s4_val;
    s5_pp     <= 33'(s4_mp) * 33'(hsv2rgb_pkg::RecipP);
    s5_pq     <= 45'(s4_mq) * 45'(hsv2rgb_pkg::RecipQ);
    s5_pt     <= 45'(s4_mt) * 45'(hsv2rgb_pkg::RecipQ);
  end

  assign term_p = s5_pp[hsv2rgb_pkg::PShift +: 8];
  assign term_q = s5_pq[hsv2rgb_pkg::QShift +: 8];
  assign term_t = s5_pt[hsv2rgb_pkg::QShift +: 8];

  // Sector permutation; grey overrides it.
  always_comb begin
    if (s5_grey) begin
      red_next   = s5_val;
      green_next = s5_val;
      blue_next  = s5_val;
    end else begin
      case (s5_sector)
        hsv2rgb_pkg::SectorRed: begin
          red_next = s5_val; green_next = term_t; blue_next = term_p;
        end
        hsv2rgb_pkg::SectorYellow: begin
          red_next = term_q; green_next = s5_val; blue_next = term_p;
        end
        hsv2rgb_pkg::SectorGreen: begin
          red_next = term_p; green_next = s5_val; blue_next = term_t;
        end
        hsv2rgb_pkg::SectorCyan: begin
          red_next = term_p; green_next = term_q; blue_next = s5_val;
        end
        hsv2rgb_pkg::SectorBlue: begin
          red_next = term_t; green_next = term_p; blue_next = s5_val;
        end
        default: begin
          red_next = s5_val; green_next = term_p; blue_next = term_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

### design/hsv2rgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound to its top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter.
module hsv2rgb_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] saturation,
  input logic [7:0] brightness,
  input logic       done,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // Only reset raises busy; with busy low the converter takes every word offered.
  assert property (@(posedge clk) disable iff (rst) !rst |=> !busy)
    else $error("busy raised outside reset");

  // Every accepted word gives one result after the pipeline depth.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hsv2rgb_pkg::PipeDepth) done)
    else $error("accepted word gave no result");

  // No result without a word accepted the pipeline depth earlier.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hsv2rgb_pkg::PipeDepth))
    else $error("result word without an accepted input");

  // Zero saturation gives grey at the brightness of the input.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && saturation == 8'd0) |-> ##(hsv2rgb_pkg::PipeDepth)
      (red == green && green == blue
       && blue == $past(brightness, hsv2rgb_pkg::PipeDepth)))
    else $error("grey input did not give grey output");

  // One channel always carries the value itself.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hsv2rgb_pkg::PipeDepth)
      (red == $past(brightness, hsv2rgb_pkg::PipeDepth)
       || green == $past(brightness, hsv2rgb_pkg::PipeDepth)
       || blue == $past(brightness, hsv2rgb_pkg::PipeDepth)))
    else $error("no channel equals the value");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .saturation  (saturation),
  .brightness  (brightness),
  .done        (done),
  .red         (red),
  .green       (green),
  .blue        (blue)
);
